/* rtl/ewma_pkg.sv */
`default_nettype none

package ewma_pkg;

  // Default sizes handed to the top level.
  localparam int unsigned MAX_ASSETS_DEF = 8;
  localparam int unsigned MAX_OBSERVATIONS_DEF = 1024;
  localparam int unsigned SAMPLE_FRACTION_BITS_DEF = 24;

  // Configuration register indexes and reset values.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_FACTOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ASSET_COUNT = 2'd1;
  localparam logic [15:0] DECAY_RESET = 16'd61604;
  localparam logic [3:0] ASSET_COUNT_RESET = 4'd8;

  // Sequencer states, one-hot.
  typedef enum logic [10:0] {
    ST_IDLE = 11'b000_0000_0001,
    ST_PRE  = 11'b000_0000_0010,
    ST_SUM  = 11'b000_0000_0100,
    ST_CHK  = 11'b000_0000_1000,
    ST_DIV  = 11'b000_0001_0000,
    ST_ROW  = 11'b000_0010_0000,
    ST_MUL  = 11'b000_0100_0000,
    ST_SCL  = 11'b000_1000_0000,
    ST_BLD  = 11'b001_0000_0000,
    ST_EMIT = 11'b010_0000_0000,
    ST_ERR  = 11'b100_0000_0000
  } state_e;

endpackage

`default_nettype wire

/* rtl/ewma_ram.sv */
`default_nettype none

module ewma_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

/* rtl/ewma_covariance_estimator_unit.sv */
`default_nettype none

// EWMA covariance estimator.
// Samples are sent on the command channel: one request is accepted at a rising edge
// with start_i high and busy_o low. Each sample is stored as it is accepted; busy_o stays
// low between samples. The request with last_sample_i set starts the computation and
// busy_o stays high until the last result has been shown.
// Results appear for one cycle each, marked by result_valid_o; the receiver cannot
// stall them. A good data set gives N*N entries in row-major order, last_entry_o on
// the final one; a ragged, empty or oversized set gives one error result.
// After the final sample come a summing pass over the stored samples, the serial mean
// divider for each asset, and for each observation the load of its centred row and an
// update of every matrix entry: the first observation writes the scaled product, each
// later one blends it into the old entry (the one shared multiplier is reused four times
// per blend); then the entries are read out through the matrix memory read port.
// Configuration writes are taken at any time through cfg_valid_i/cfg_ready_o.
// Reset clears the load count and the overflow mark; memories hold no reset value.
module ewma_covariance_estimator_unit #(
  parameter int unsigned MAX_ASSETS = ewma_pkg::MAX_ASSETS_DEF,
  parameter int unsigned MAX_OBSERVATIONS = ewma_pkg::MAX_OBSERVATIONS_DEF,
  parameter int unsigned SAMPLE_FRACTION_BITS = ewma_pkg::SAMPLE_FRACTION_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  output logic                                busy_o,
  input  wire logic signed [31:0]             return_sample_i,
  input  wire logic                           last_sample_i,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [ewma_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [15:0]                    cfg_data_i,
  output logic                                result_valid_o,
  output logic [2:0]                          row_index_o,
  output logic [2:0]                          column_index_o,
  output logic signed [63:0]                  covariance_value_o,
  output logic                                last_entry_o,
  output logic                                error_flag_o
);

  localparam int unsigned AW = (MAX_ASSETS > 1) ? $clog2(MAX_ASSETS) : 1;
  localparam int unsigned NW = $clog2(MAX_ASSETS + 1);
  localparam int unsigned DEPTH = MAX_ASSETS * MAX_OBSERVATIONS;
  localparam int unsigned SAW = $clog2(DEPTH);
  localparam int unsigned CW = SAW + 1;
  localparam int unsigned SUM_W = 32 + $clog2(MAX_OBSERVATIONS + 1);
  localparam int unsigned DVW = SUM_W + 1;
  localparam int unsigned DCW = $clog2(DVW + 1);
  localparam int unsigned CAW = 2 * AW;
  localparam int unsigned FB = 2 * SAMPLE_FRACTION_BITS;
  localparam int unsigned SHR = (FB > 48) ? FB - 48 : 1;
  localparam int unsigned SHL = (FB < 48) ? 48 - FB : 0;

  ewma_pkg::state_e state_q, state_d;

  logic [15:0]          decay_q, decay_d;
  logic [3:0]           acnt_q, acnt_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic                 ovf_q, ovf_d;
  logic [NW-1:0]        n_q, n_d;
  logic                 ph_q, ph_d;
  logic [CW-1:0]        addr_q, addr_d;
  logic [AW-1:0]        col_q, col_d;
  logic [CW-1:0]        obs_q, obs_d;
  logic signed [SUM_W-1:0] sums_q [MAX_ASSETS];
  logic signed [SUM_W-1:0] sums_d [MAX_ASSETS];
  logic signed [31:0]   means_q [MAX_ASSETS];
  logic signed [31:0]   means_d [MAX_ASSETS];
  logic signed [32:0]   r_q [MAX_ASSETS];
  logic signed [32:0]   r_d [MAX_ASSETS];
  logic [AW-1:0]        i_q, i_d, j_q, j_d;
  logic [CW-1:0]        base_q, base_d;
  logic [CW-1:0]        tcnt_q, tcnt_d;
  logic                 first_q, first_d;
  logic [CW-1:0]        rem_q, rem_d;
  logic [DVW-1:0]       quo_q, quo_d;
  logic [DCW-1:0]       dcnt_q, dcnt_d;
  logic                 dneg_q, dneg_d;
  logic signed [67:0]   prod_q;
  logic [63:0]          p_q, p_d, c_q, c_d;
  logic signed [83:0]   acc_q, acc_d;
  logic [2:0]           step_q, step_d;
  logic                 ov_q, ov_d;
  logic [2:0]           orow_q, orow_d, ocol_q, ocol_d;
  logic [63:0]          oval_q, oval_d;
  logic                 olast_q, olast_d, oerr_q, oerr_d;

  logic                 accept;
  logic [SAW-1:0]       st_raddr;
  logic [31:0]          st_rdata;
  logic                 cov_we;
  logic [CAW-1:0]       cov_waddr, cov_raddr;
  logic [63:0]          cov_wdata, cov_rdata;
  logic signed [33:0]   mul_a, mul_b;
  logic [67:0]          pmag, smag, limit;
  logic                 pneg;
  logic [63:0]          p_s;
  logic                 col_last, i_last, j_last;
  logic [CW:0]          trial;
  logic                 qbit;
  logic [DVW-1:0]       qnew;
  logic [SUM_W-1:0]     smag_abs;
  logic signed [83:0]   acc_rnd;
  logic [16:0]          weight_k;

  assign accept = start_i && !busy_o;
  assign busy_o = (state_q != ewma_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;

  assign col_last = ((NW + 1)'(col_q) + 1'b1) == (NW + 1)'(n_q);
  assign i_last = ((NW + 1)'(i_q) + 1'b1) == (NW + 1)'(n_q);
  assign j_last = ((NW + 1)'(j_q) + 1'b1) == (NW + 1)'(n_q);
  assign weight_k = 17'h10000 - {1'b0, decay_q};

  // Sample store and covariance matrix memories.
  ewma_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_store (
    .clk_i   (clk_i),
    .we_i    (accept && (cnt_q < CW'(DEPTH))),
    .waddr_i (cnt_q[SAW-1:0]),
    .wdata_i (return_sample_i),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  ewma_ram #(.WIDTH(64), .DEPTH(1 << CAW)) u_cov (
    .clk_i   (clk_i),
    .we_i    (cov_we),
    .waddr_i (cov_waddr),
    .wdata_i (cov_wdata),
    .raddr_i (cov_raddr),
    .rdata_o (cov_rdata)
  );

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = 34'(r_q[i_q]);
    mul_b = 34'(r_q[j_q]);
    if (state_q == ewma_pkg::ST_BLD) begin
      case (step_q)
        3'd1: begin
          mul_a = {18'b0, decay_q};
          mul_b = {2'b0, c_q[31:0]};
        end
        3'd2: begin
          mul_a = {18'b0, decay_q};
          mul_b = 34'(signed'(c_q[63:32]));
        end
        3'd3: begin
          mul_a = {17'b0, weight_k};
          mul_b = {2'b0, p_q[31:0]};
        end
        3'd4: begin
          mul_a = {17'b0, weight_k};
          mul_b = 34'(signed'(p_q[63:32]));
        end
        default: begin
          mul_a = 34'(r_q[i_q]);
          mul_b = 34'(r_q[j_q]);
        end
      endcase
    end
  end

  // Product scaled to 48 fraction bits, rounded on the magnitude and saturated.
  always_comb begin
    pneg = prod_q[67];
    pmag = pneg ? 68'(-prod_q) : 68'(prod_q);
    limit = pneg ? 68'h0_8000_0000_0000_0000 : 68'h0_7FFF_FFFF_FFFF_FFFF;
    smag = pmag;
    if (FB > 48) begin
      smag = (pmag >> SHR) + {67'b0, pmag[SHR-1]};
    end else if (FB < 48) begin
      smag = (pmag > (limit >> SHL)) ? limit : (pmag << SHL);
    end
    if (smag > limit) begin
      smag = limit;
    end
    p_s = pneg ? 64'(~smag + 68'd1) : smag[63:0];
  end

  // Serial divider step.
  always_comb begin
    trial = {rem_q, quo_q[DVW-1]};
    qbit = (trial >= (CW + 1)'(obs_q));
    qnew = {quo_q[DVW-2:0], qbit};
  end

  assign smag_abs = sums_q[i_q][SUM_W-1] ? SUM_W'(-sums_q[i_q]) : SUM_W'(sums_q[i_q]);
  assign acc_rnd = acc_q + 84'sd32768;

  // Sequencer.
  always_comb begin
    state_d = state_q;
    decay_d = decay_q;
    acnt_d = acnt_q;
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    n_d = n_q;
    ph_d = ph_q;
    addr_d = addr_q;
    col_d = col_q;
    obs_d = obs_q;
    sums_d = sums_q;
    means_d = means_q;
    r_d = r_q;
    i_d = i_q;
    j_d = j_q;
    base_d = base_q;
    tcnt_d = tcnt_q;
    first_d = first_q;
    rem_d = rem_q;
    quo_d = quo_q;
    dcnt_d = dcnt_q;
    dneg_d = dneg_q;
    p_d = p_q;
    c_d = c_q;
    acc_d = acc_q;
    step_d = step_q;
    ov_d = 1'b0;
    orow_d = orow_q;
    ocol_d = ocol_q;
    oval_d = oval_q;
    olast_d = olast_q;
    oerr_d = oerr_q;
    st_raddr = addr_q[SAW-1:0];
    cov_we = 1'b0;
    cov_waddr = {i_q, j_q};
    cov_wdata = p_s;
    cov_raddr = {i_q, j_q};

    // Configuration writes.
    if (cfg_valid_i) begin
      if (cfg_index_i == ewma_pkg::CFG_DECAY_FACTOR) begin
        decay_d = cfg_data_i;
      end else if (cfg_index_i == ewma_pkg::CFG_ASSET_COUNT) begin
        acnt_d = cfg_data_i[3:0];
      end
    end

    case (state_q)
      ewma_pkg::ST_IDLE: begin
        if (accept) begin
          if (cnt_q < CW'(DEPTH)) begin
            cnt_d = cnt_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          if (last_sample_i) begin
            if (acnt_q == 4'd0) begin
              n_d = NW'(1);
            end else if (32'(acnt_q) > MAX_ASSETS) begin
              n_d = NW'(MAX_ASSETS);
            end else begin
              n_d = NW'(acnt_q);
            end
            state_d = ewma_pkg::ST_PRE;
          end
        end
      end
      ewma_pkg::ST_PRE: begin
        if (ovf_q || cnt_q == '0) begin
          state_d = ewma_pkg::ST_ERR;
        end else begin
          for (int k = 0; k < MAX_ASSETS; k++) begin
            sums_d[k] = '0;
          end
          addr_d = '0;
          col_d = '0;
          obs_d = '0;
          ph_d = 1'b0;
          state_d = ewma_pkg::ST_SUM;
        end
      end
      // Column sums over the whole store, counting complete rows.
      ewma_pkg::ST_SUM: begin
        if (!ph_q) begin
          ph_d = 1'b1;
        end else begin
          ph_d = 1'b0;
          sums_d[col_q] = sums_q[col_q] + SUM_W'(signed'(st_rdata));
          if (col_last) begin
            col_d = '0;
            obs_d = obs_q + 1'b1;
          end else begin
            col_d = col_q + 1'b1;
          end
          addr_d = addr_q + 1'b1;
          if (addr_q + 1'b1 == cnt_q) begin
            state_d = ewma_pkg::ST_CHK;
          end
        end
      end
      ewma_pkg::ST_CHK: begin
        if (col_q != '0 || 32'(obs_q) > MAX_OBSERVATIONS) begin
          state_d = ewma_pkg::ST_ERR;
        end else begin
          i_d = '0;
          ph_d = 1'b0;
          state_d = ewma_pkg::ST_DIV;
        end
      end
      // Rounded mean of each column, one quotient bit a cycle.
      ewma_pkg::ST_DIV: begin
        if (!ph_q) begin
          quo_d = DVW'(smag_abs) + DVW'(obs_q >> 1);
          rem_d = '0;
          dcnt_d = '0;
          dneg_d = sums_q[i_q][SUM_W-1];
          ph_d = 1'b1;
        end else begin
          rem_d = qbit ? CW'(trial - (CW + 1)'(obs_q)) : CW'(trial);
          quo_d = qnew;
          dcnt_d = dcnt_q + 1'b1;
          if (dcnt_q == DCW'(DVW - 1)) begin
            means_d[i_q] = dneg_q ? 32'(~qnew + 1'b1) : 32'(qnew);
            ph_d = 1'b0;
            if (i_last) begin
              i_d = '0;
              base_d = '0;
              tcnt_d = '0;
              first_d = 1'b1;
              state_d = ewma_pkg::ST_ROW;
            end else begin
              i_d = i_q + 1'b1;
            end
          end
        end
      end
      // Centred row of the current observation.
      ewma_pkg::ST_ROW: begin
        st_raddr = SAW'(base_q + CW'(i_q));
        if (!ph_q) begin
          ph_d = 1'b1;
        end else begin
          ph_d = 1'b0;
          r_d[i_q] = 33'(signed'(st_rdata)) - 33'(means_q[i_q]);
          if (i_last) begin
            i_d = '0;
            j_d = '0;
            state_d = ewma_pkg::ST_MUL;
          end else begin
            i_d = i_q + 1'b1;
          end
        end
      end
      ewma_pkg::ST_MUL: begin
        state_d = ewma_pkg::ST_SCL;
      end
      ewma_pkg::ST_SCL: begin
        p_d = p_s;
        step_d = '0;
        if (first_q) begin
          cov_we = 1'b1;
        end else begin
          state_d = ewma_pkg::ST_BLD;
        end
      end
      // Blend of old entry and new product through the shared multiplier.
      ewma_pkg::ST_BLD: begin
        step_d = step_q + 1'b1;
        case (step_q)
          3'd0: c_d = cov_rdata;
          3'd2: acc_d = 84'(prod_q);
          3'd3: acc_d = acc_q + (84'(prod_q) <<< 32);
          3'd4: acc_d = acc_q + 84'(prod_q);
          3'd5: acc_d = acc_q + (84'(prod_q) <<< 32);
          3'd6: begin
            cov_we = 1'b1;
            cov_wdata = acc_rnd[79:16];
          end
          default: acc_d = acc_q;
        endcase
      end
      // Matrix read-out.
      ewma_pkg::ST_EMIT: begin
        if (!ph_q) begin
          ph_d = 1'b1;
        end else begin
          ph_d = 1'b0;
          ov_d = 1'b1;
          orow_d = 3'(i_q);
          ocol_d = 3'(j_q);
          oval_d = cov_rdata;
          olast_d = i_last && j_last;
          oerr_d = 1'b0;
          if (j_last) begin
            j_d = '0;
            if (i_last) begin
              i_d = '0;
              cnt_d = '0;
              ovf_d = 1'b0;
              state_d = ewma_pkg::ST_IDLE;
            end else begin
              i_d = i_q + 1'b1;
            end
          end else begin
            j_d = j_q + 1'b1;
          end
        end
      end
      ewma_pkg::ST_ERR: begin
        ov_d = 1'b1;
        orow_d = '0;
        ocol_d = '0;
        oval_d = '0;
        olast_d = 1'b1;
        oerr_d = 1'b1;
        cnt_d = '0;
        ovf_d = 1'b0;
        state_d = ewma_pkg::ST_IDLE;
      end
      default: state_d = ewma_pkg::ST_IDLE;
    endcase

    // Step to the next matrix entry once the current one is written.
    if ((state_q == ewma_pkg::ST_SCL && first_q) ||
        (state_q == ewma_pkg::ST_BLD && step_q == 3'd6)) begin
      state_d = ewma_pkg::ST_MUL;
      if (j_last) begin
        j_d = '0;
        if (i_last) begin
          i_d = '0;
          ph_d = 1'b0;
          tcnt_d = tcnt_q + 1'b1;
          first_d = 1'b0;
          base_d = base_q + CW'(n_q);
          state_d = (tcnt_q + 1'b1 == obs_q) ? ewma_pkg::ST_EMIT : ewma_pkg::ST_ROW;
        end else begin
          i_d = i_q + 1'b1;
        end
      end else begin
        j_d = j_q + 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ewma_pkg::ST_IDLE;
      decay_q <= ewma_pkg::DECAY_RESET;
      acnt_q <= ewma_pkg::ASSET_COUNT_RESET;
      cnt_q <= '0;
      ovf_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      decay_q <= decay_d;
      acnt_q <= acnt_d;
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
      ov_q <= ov_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    n_q <= n_d;
    ph_q <= ph_d;
    addr_q <= addr_d;
    col_q <= col_d;
    obs_q <= obs_d;
    sums_q <= sums_d;
    means_q <= means_d;
    r_q <= r_d;
    i_q <= i_d;
    j_q <= j_d;
    base_q <= base_d;
    tcnt_q <= tcnt_d;
    first_q <= first_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    dcnt_q <= dcnt_d;
    dneg_q <= dneg_d;
    prod_q <= mul_a * mul_b;
    p_q <= p_d;
    c_q <= c_d;
    acc_q <= acc_d;
    step_q <= step_d;
    orow_q <= orow_d;
    ocol_q <= ocol_d;
    oval_q <= oval_d;
    olast_q <= olast_d;
    oerr_q <= oerr_d;
  end

  assign result_valid_o = ov_q;
  assign row_index_o = orow_q;
  assign column_index_o = ocol_q;
  assign covariance_value_o = oval_q;
  assign last_entry_o = olast_q;
  assign error_flag_o = oerr_q;

  // An error result is always a lone final result with a zero value.
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && error_flag_o |-> last_entry_o && covariance_value_o == 64'd0)
    else $error("error result not final or not zero");

  // A plain sample does not start the computation.
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && !last_sample_i |=> !busy_o)
    else $error("block busy after a plain sample");

  // The final sample always starts the computation.
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && last_sample_i |=> busy_o)
    else $error("block not busy after final sample");

  // After the final entry the block is idle again.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_entry_o |-> !busy_o)
    else $error("block still busy after final result");

endmodule

`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;

  typedef struct packed {
    logic [2:0]  row;
    logic [2:0]  col;
    logic [63:0] value;
    logic        last;
    logic        err;
  } cov_entry_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [31:0] return_sample_i = '0;
  logic        last_sample_i = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [ewma_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        result_valid_o;
  logic [2:0]  row_index_o;
  logic [2:0]  column_index_o;
  logic [63:0] covariance_value_o;
  logic        last_entry_o;
  logic        error_flag_o;

  // Predictor state: its own copy of the registers and the loaded samples.
  logic [15:0] pred_decay = ewma_pkg::DECAY_RESET;
  logic [3:0]  pred_assets = ewma_pkg::ASSET_COUNT_RESET;
  logic [31:0] pred_store [8192];
  int unsigned pred_loaded = 0;
  bit          pred_overflow = 0;
  logic [63:0] pred_cov [8][8];

  cov_entry_t  pending_entries[$];
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  bit          steady = 0;

  ewma_covariance_estimator_unit i_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .return_sample_i, .last_sample_i,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i, .result_valid_o,
    .row_index_o, .column_index_o, .covariance_value_o, .last_entry_o, .error_flag_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Centred product in Q16.48, saturated, with the magnitude product kept to 64 bits.
  function automatic logic [63:0] q48_product(longint a, longint b);
    logic [63:0] ma, mb, mag, lim;
    logic neg;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    mag = ma * mb;
    neg = ((a < 0) != (b < 0)) && (mag != 0);
    lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    if (mag > lim) mag = lim;
    return neg ? -mag : mag;
  endfunction

  // Weighted mix of the old entry and the new product, rounded half up.
  function automatic logic [63:0] ewma_mix(logic [63:0] c, logic [63:0] p, logic [15:0] lam);
    logic [63:0] l, k, frac, fc, fp;
    l = {48'd0, lam};
    k = 64'd65536 - l;
    frac = l * {48'd0, c[15:0]} + k * {48'd0, p[15:0]};
    fc = {{16{c[63]}}, c[63:16]};
    fp = {{16{p[63]}}, p[63:16]};
    return l * fc + k * fp + ((frac + 64'd32768) >> 16);
  endfunction

  // Works out the results of a finished data set and queues them.
  task automatic predict_matrix();
    int unsigned n, obs;
    longint sums [8];
    longint means [8];
    longint r [8];
    logic [63:0] mag, p;
    cov_entry_t e;
    n = (pred_assets == 0) ? 1 : (pred_assets > 8) ? 8 : pred_assets;
    obs = pred_loaded / n;
    if (pred_overflow || (pred_loaded % n) != 0 || obs > 1024) begin
      e = '{row: 3'd0, col: 3'd0, value: 64'd0, last: 1'b1, err: 1'b1};
      pending_entries.push_back(e);
    end else begin
      for (int i = 0; i < 8; i++) sums[i] = 0;
      for (int t = 0; t < obs; t++)
        for (int i = 0; i < n; i++) sums[i] += longint'($signed(pred_store[t*n+i]));
      for (int i = 0; i < n; i++) begin
        mag = (sums[i] < 0) ? -sums[i] : sums[i];
        mag = (mag + obs / 2) / obs;
        means[i] = (sums[i] < 0) ? -longint'(mag) : longint'(mag);
      end
      for (int t = 0; t < obs; t++) begin
        for (int i = 0; i < n; i++) r[i] = longint'($signed(pred_store[t*n+i])) - means[i];
        for (int i = 0; i < n; i++)
          for (int j = 0; j < n; j++) begin
            p = q48_product(r[i], r[j]);
            pred_cov[i][j] = (t == 0) ? p : ewma_mix(pred_cov[i][j], p, pred_decay);
          end
      end
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n; j++) begin
          e.row = i[2:0];
          e.col = j[2:0];
          e.value = pred_cov[i][j];
          e.last = (i == n - 1) && (j == n - 1);
          e.err = 1'b0;
          pending_entries.push_back(e);
        end
    end
    pred_loaded = 0;
    pred_overflow = 0;
  endtask

  // Sends one sample request and updates the predictor once it is taken.
  task automatic send_sample(logic [31:0] value, logic last);
    while (!steady && $urandom_range(99) < 29) begin
      @(negedge clk_i);
      start_i = 1'b0;
    end
    @(negedge clk_i);
    start_i = 1'b1;
    return_sample_i = value;
    last_sample_i = last;
    do @(posedge clk_i); while (busy_o);
    items_sent++;
    if (pred_loaded < 8192) begin
      pred_store[pred_loaded] = value;
      pred_loaded++;
    end else begin
      pred_overflow = 1;
    end
    if (last) begin
      predict_matrix();
      @(negedge clk_i);
      start_i = 1'b0;
    end
  endtask

  // Waits until every queued result has been shown and the block has settled.
  task automatic drain();
    while (pending_entries.size() != 0) @(posedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // Register write, only issued while the block is idle.
  task automatic write_reg(logic [ewma_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
    drain();
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == ewma_pkg::CFG_DECAY_FACTOR) pred_decay = data;
    else if (idx == ewma_pkg::CFG_ASSET_COUNT) pred_assets = data[3:0];
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic [31:0] random_sample();
    if ($urandom_range(1)) return $urandom;
    return 32'($signed($urandom_range(16777216*4)) - 32'sd33554432);
  endfunction

  // Sends a data set of total samples, the last one marked as final.
  task automatic send_set(int unsigned total);
    for (int k = 0; k < total; k++) send_sample(random_sample(), k == total - 1);
  endtask

  task automatic test_reset_values();
    send_set(16);
  endtask

  task automatic test_single_observation();
    write_reg(ewma_pkg::CFG_ASSET_COUNT, 16'd3);
    send_set(3);
  endtask

  task automatic test_extremes();
    write_reg(ewma_pkg::CFG_ASSET_COUNT, 16'd2);
    write_reg(ewma_pkg::CFG_DECAY_FACTOR, 16'd65535);
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b1);
    write_reg(ewma_pkg::CFG_DECAY_FACTOR, 16'd1);
    send_sample(32'h0000_0000, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'h0000_0001, 1'b0);
    send_sample(32'h8000_0000, 1'b1);
  endtask

  task automatic test_decay_zero();
    write_reg(ewma_pkg::CFG_DECAY_FACTOR, 16'd0);
    send_set(4);
  endtask

  task automatic test_asset_count_clamp();
    write_reg(ewma_pkg::CFG_ASSET_COUNT, 16'd0);
    write_reg(ewma_pkg::CFG_DECAY_FACTOR, 16'd32768);
    send_set(2);
    write_reg(ewma_pkg::CFG_ASSET_COUNT, 16'd15);
    send_set(16);
  endtask

  task automatic test_ragged_set();
    write_reg(ewma_pkg::CFG_ASSET_COUNT, 16'd3);
    send_set(5);
  endtask

  task automatic test_random_sets();
    int unsigned n, total, sets;
    sets = 0;
    while (items_sent < 360) begin
      steady = (sets >= 4 && sets < 10);
      case ($urandom_range(5))
        0: write_reg(ewma_pkg::CFG_DECAY_FACTOR, 16'd65535);
        1: write_reg(ewma_pkg::CFG_DECAY_FACTOR, 16'd1);
        default: write_reg(ewma_pkg::CFG_DECAY_FACTOR, 16'($urandom));
      endcase
      n = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(8, 1);
      write_reg(ewma_pkg::CFG_ASSET_COUNT, 16'(n));
      n = (n == 0) ? 1 : (n > 8) ? 8 : n;
      total = n * $urandom_range(4, 1);
      if ($urandom_range(99) < 15) total = total + $urandom_range(n) + 1;
      send_set(total);
      sets++;
    end
    steady = 0;
  endtask

  // Compares every shown result with the oldest prediction.
  always @(posedge clk_i) begin
    cov_entry_t e;
    if (rst_ni && result_valid_o) begin
      if (pending_entries.size() == 0) begin
        $display("%0t: unexpected result row %0d col %0d value %h", $time,
                 row_index_o, column_index_o, covariance_value_o);
        mismatches++;
      end else begin
        e = pending_entries.pop_front();
        if (row_index_o !== e.row || column_index_o !== e.col ||
            covariance_value_o !== e.value || last_entry_o !== e.last ||
            error_flag_o !== e.err) begin
          $display("%0t: mismatch expected row %0d col %0d value %h last %b err %b",
                   $time, e.row, e.col, e.value, e.last, e.err);
          $display("%0t:          actual   row %0d col %0d value %h last %b err %b",
                   $time, row_index_o, column_index_o, covariance_value_o,
                   last_entry_o, error_flag_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);
    test_reset_values();
    test_single_observation();
    test_extremes();
    test_decay_zero();
    test_asset_count_clamp();
    test_ragged_set();
    test_random_sets();
    drain();
    repeat (50) @(negedge clk_i);
    if (mismatches == 0 && pending_entries.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Guard against a hung block.
  initial begin
    #8000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* sim.f */
rtl/ewma_pkg.sv
rtl/ewma_ram.sv
rtl/ewma_covariance_estimator_unit.sv
test/tb.sv
